// ----- sv/scar_pkg.sv -----
// Package with types, constants and tuning tables for the stereo reverb.
package scar_pkg;

  localparam int SampleW = 24;
  localparam int CfgW = 17;
  localparam int CfgIdxW = 3;
  localparam int QOne = 65536;
  localparam int GainQ16 = 983;
  localparam int RoomOffQ16 = 45875;
  localparam int RoomScaleQ16 = 18350;
  localparam int DampScaleQ16 = 26214;

  localparam int DefCombCount = 8;
  localparam int DefApCount = 4;
  localparam int DefSpread = 23;
  localparam int MaxCombs = 16;
  localparam int MaxAps = 8;
  localparam int CombCap = 2143 + 64;
  localparam int ApCap = 556 + 64;

  localparam logic [CfgIdxW-1:0] RegRoom = 3'd0;
  localparam logic [CfgIdxW-1:0] RegDamp = 3'd1;
  localparam logic [CfgIdxW-1:0] RegWet = 3'd2;
  localparam logic [CfgIdxW-1:0] RegDry = 3'd3;
  localparam logic [CfgIdxW-1:0] RegWidth = 3'd4;
  localparam logic [CfgIdxW-1:0] RegFreeze = 3'd5;

  typedef struct packed {
    logic signed [SampleW-1:0] in_left;
    logic signed [SampleW-1:0] in_right;
  } in_beat_t;

  typedef struct packed {
    logic signed [SampleW-1:0] out_left;
    logic signed [SampleW-1:0] out_right;
  } out_beat_t;

  typedef enum logic [3:0] {
    StIdle, StCoef, StFeed, StCombRd, StCombLp, StCombWr, StApRd, StApWr,
    StMix1, StMix2, StMix3, StOut, StClear
  } state_e;

  // Base lengths of the comb lines.
  function automatic int comb_len(input int k);
    case (k)
      0: comb_len = 1116;  1: comb_len = 1188;  2: comb_len = 1277;
      3: comb_len = 1356;  4: comb_len = 1422;  5: comb_len = 1491;
      6: comb_len = 1557;  7: comb_len = 1617;  8: comb_len = 1687;
      9: comb_len = 1753;  10: comb_len = 1823; 11: comb_len = 1889;
      12: comb_len = 1951; 13: comb_len = 2017; 14: comb_len = 2083;
      default: comb_len = 2143;
    endcase
  endfunction

  // Base lengths of the allpass lines.
  function automatic int ap_len(input int k);
    case (k)
      0: ap_len = 556; 1: ap_len = 441; 2: ap_len = 341; 3: ap_len = 225;
      4: ap_len = 179; 5: ap_len = 137; 6: ap_len = 101;
      default: ap_len = 73;
    endcase
  endfunction

endpackage

// ----- sv/stereo_comb_allpass_reverb.sv -----
// Top level of the stereo comb/allpass reverberator.
// One stereo frame is processed at a time. After a frame is accepted the
// sequencer runs the setup states StCoef and StFeed, then StCombRd, StCombLp
// and StCombWr for each of the 2*COMB_COUNT comb lines and StApRd and StApWr
// for each of the 2*ALLPASS_COUNT allpass stages through the single comb and
// allpass memory ports, then the mixing states StMix1 to StMix3 and StOut.
// The result sits in an output register and the next frame may be accepted
// while it waits. After reset a clearing pass writes zero to every word of
// the comb memory; frames are not accepted during it, configuration writes
// are.
module stereo_comb_allpass_reverb
  import scar_pkg::*;
#(
  parameter int COMB_COUNT = DefCombCount,
  parameter int ALLPASS_COUNT = DefApCount,
  parameter int STEREO_SPREAD = DefSpread
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  in_beat_t            in_data_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output out_beat_t           out_data_o,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [CfgW-1:0]     cfg_data_i
);

  localparam int NComb = 2 * COMB_COUNT;
  localparam int NAp = 2 * ALLPASS_COUNT;
  localparam int CombDepth = NComb * CombCap;
  localparam int ApDepth = NAp * ApCap;
  localparam int CombAW = $clog2(CombDepth);
  localparam int ApAW = $clog2(ApDepth);
  localparam int CIdxW = $clog2(NComb + 1);
  localparam int AIdxW = $clog2(NAp + 1);
  localparam int PosW = $clog2(CombCap);
  localparam int AccW = SampleW + 6;
  localparam logic signed [SampleW-1:0] SMax = {1'b0, {(SampleW-1){1'b1}}};
  localparam logic signed [SampleW-1:0] SMin = {1'b1, {(SampleW-1){1'b0}}};

  // Saturate a wide value to a sample.
  function automatic logic signed [SampleW-1:0] sat(input logic signed [63:0] x);
    if (x > 64'(signed'(SMax))) sat = SMax;
    else if (x < 64'(signed'(SMin))) sat = SMin;
    else sat = x[SampleW-1:0];
  endfunction

  // Round half up at Q16.
  function automatic logic signed [63:0] rnd16(input logic signed [63:0] x);
    rnd16 = (x + 64'sd32768) >>> 16;
  endfunction

  function automatic logic [CfgW-1:0] clampq(input logic [CfgW-1:0] v);
    clampq = (v > CfgW'(QOne)) ? CfgW'(QOne) : v;
  endfunction

  // Line lengths.
  function automatic logic [PosW-1:0] c_len(input int i);
    c_len = (i >= COMB_COUNT) ? PosW'(comb_len(i - COMB_COUNT) + STEREO_SPREAD)
                              : PosW'(comb_len(i));
  endfunction
  function automatic logic [PosW-1:0] a_len(input int i);
    a_len = (i >= ALLPASS_COUNT) ? PosW'(ap_len(i - ALLPASS_COUNT) + STEREO_SPREAD)
                                 : PosW'(ap_len(i));
  endfunction

  // Configuration registers.
  logic [CfgW-1:0] room_q, damp_q, wet_q, dry_q, width_q;
  logic freeze_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      room_q <= CfgW'(32768);
      damp_q <= CfgW'(32768);
      wet_q <= CfgW'(21845);
      dry_q <= '0;
      width_q <= CfgW'(QOne);
      freeze_q <= 1'b0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        RegRoom: room_q <= cfg_data_i;
        RegDamp: damp_q <= cfg_data_i;
        RegWet: wet_q <= cfg_data_i;
        RegDry: dry_q <= cfg_data_i;
        RegWidth: width_q <= cfg_data_i;
        RegFreeze: freeze_q <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  state_e state_q, state_d;
  logic [CIdxW-1:0] ci_q, ci_d;
  logic [AIdxW-1:0] ai_q, ai_d;
  logic [CombAW-1:0] clr_q, clr_d;
  logic [PosW-1:0] cpos_q [NComb];
  logic [PosW-1:0] apos_q [NAp];
  logic signed [SampleW-1:0] lp_q [NComb];
  logic signed [SampleW-1:0] inl_q, inr_q, feed_q;
  logic signed [18:0] fb_q;
  logic signed [17:0] d1_q, d2_q;
  logic signed [AccW-1:0] accl_q, accr_q, cur_q;
  logic signed [SampleW-1:0] lpn_q;
  logic signed [19:0] wet1_q, wet2_q, dry_q2;
  logic signed [63:0] m1_q, m2_q, m3_q, m4_q, m5_q, m6_q;
  out_beat_t out_q;
  logic out_vld_q;

  // A lap flag per allpass stage marks that its line has been written all
  // the way around once.
  logic [NAp-1:0] ap_lap_q;

  // Memory ports.
  logic c_we, a_we;
  logic [CombAW-1:0] c_waddr, c_raddr;
  logic [ApAW-1:0] a_waddr, a_raddr;
  logic signed [SampleW-1:0] c_wdata, a_wdata, c_rdata, a_rdata;

  scar_ram #(.Width(SampleW), .Depth(CombDepth)) u_comb_ram (
    .clk_i, .we_i(c_we), .waddr_i(c_waddr), .wdata_i(c_wdata),
    .raddr_i(c_raddr), .rdata_o(c_rdata)
  );
  scar_ram #(.Width(SampleW), .Depth(ApDepth)) u_ap_ram (
    .clk_i, .we_i(a_we), .waddr_i(a_waddr), .wdata_i(a_wdata),
    .raddr_i(a_raddr), .rdata_o(a_rdata)
  );

  logic [$clog2(NComb)-1:0] cix;
  logic [$clog2(NAp)-1:0] aix;
  assign cix = ci_q[$clog2(NComb)-1:0];
  assign aix = ai_q[$clog2(NAp)-1:0];

  logic [PosW-1:0] cpos_cur, apos_cur;
  assign cpos_cur = cpos_q[cix];
  assign apos_cur = apos_q[aix];

  // Allpass words never written read as zero during the first lap.
  logic signed [SampleW-1:0] held;
  assign held = ap_lap_q[aix] ? a_rdata : '0;

  assign in_stall_o = (state_q != StIdle);

  // Next state.
  always_comb begin
    state_d = state_q;
    ci_d = ci_q;
    ai_d = ai_q;
    clr_d = clr_q;
    case (state_q)
      StClear: begin
        clr_d = clr_q + 1'b1;
        if (clr_q == CombAW'(CombDepth - 1)) state_d = StIdle;
      end
      StIdle: if (in_valid_i && !in_stall_o) state_d = StCoef;
      StCoef: state_d = StFeed;
      StFeed: begin
        ci_d = '0;
        state_d = StCombRd;
      end
      StCombRd: state_d = StCombLp;
      StCombLp: state_d = StCombWr;
      StCombWr: begin
        ci_d = ci_q + 1'b1;
        ai_d = '0;
        state_d = (ci_q == CIdxW'(NComb - 1)) ? StApRd : StCombRd;
      end
      StApRd: state_d = StApWr;
      StApWr: begin
        ai_d = ai_q + 1'b1;
        state_d = (ai_q == AIdxW'(NAp - 1)) ? StMix1 : StApRd;
      end
      StMix1: state_d = StMix2;
      StMix2: state_d = StMix3;
      StMix3: state_d = StOut;
      StOut: if (!(out_vld_q && out_stall_i)) state_d = StIdle;
      default: state_d = StIdle;
    endcase
  end

  // Memory port control.
  always_comb begin
    c_we = 1'b0;
    a_we = 1'b0;
    c_raddr = CombAW'(cix * CombCap) + CombAW'(cpos_cur);
    c_waddr = c_raddr;
    a_raddr = ApAW'(aix * ApCap) + ApAW'(apos_cur);
    a_waddr = a_raddr;
    c_wdata = sat(64'(feed_q) + rnd16(64'(lpn_q) * 64'(fb_q)));
    a_wdata = sat(64'(cur_q) + ((64'(held) + 64'sd1) >>> 1));
    case (state_q)
      StClear: begin
        c_we = 1'b1;
        c_waddr = clr_q;
        c_wdata = '0;
      end
      StCombWr: c_we = 1'b1;
      StApWr: a_we = 1'b1;
      default: ;
    endcase
  end

  // Datapath.
  logic signed [63:0] lp_prev;
  assign lp_prev = 64'(lp_q[cix]);

  always_ff @(posedge clk_i) begin
    case (state_q)
      StIdle: begin
        inl_q <= in_data_i.in_left;
        inr_q <= in_data_i.in_right;
      end
      StCoef: begin
        if (freeze_q) begin
          fb_q <= 19'(QOne);
          d1_q <= '0;
          d2_q <= 18'(QOne);
        end else begin
          fb_q <= 19'(RoomOffQ16 + rnd16(64'(clampq(room_q)) * RoomScaleQ16));
          d1_q <= 18'(rnd16(64'(clampq(damp_q)) * DampScaleQ16));
          d2_q <= 18'(QOne - rnd16(64'(clampq(damp_q)) * DampScaleQ16));
        end
      end
      StFeed: begin
        feed_q <= freeze_q ? '0 : SampleW'(rnd16((64'(inl_q) + 64'(inr_q)) * GainQ16));
        accl_q <= '0;
        accr_q <= '0;
      end
      StCombLp: lpn_q <= sat(rnd16(64'(c_rdata) * 64'(d2_q) + lp_prev * 64'(d1_q)));
      StCombWr: begin
        if (ci_q < CIdxW'(COMB_COUNT)) accl_q <= accl_q + AccW'(c_rdata);
        else accr_q <= accr_q + AccW'(c_rdata);
        if (ci_q == CIdxW'(NComb - 1)) cur_q <= accl_q;
      end
      StApRd: ;
      StApWr: begin
        if (ai_q < AIdxW'(ALLPASS_COUNT)) begin
          accl_q <= AccW'(64'(held) - 64'(cur_q));
          cur_q <= (ai_q == AIdxW'(ALLPASS_COUNT - 1)) ? accr_q
                   : AccW'(64'(held) - 64'(cur_q));
        end else begin
          accr_q <= AccW'(64'(held) - 64'(cur_q));
          cur_q <= AccW'(64'(held) - 64'(cur_q));
        end
      end
      StMix1: begin
        wet1_q <= 20'(rnd16((64'(3 * clampq(wet_q)) * (64'(clampq(width_q)) + QOne)) >>> 1));
        wet2_q <= 20'(rnd16((64'(3 * clampq(wet_q)) * (QOne - 64'(clampq(width_q)))) >>> 1));
        dry_q2 <= 20'(2 * clampq(dry_q));
      end
      StMix2: begin
        m1_q <= 64'(accl_q) * 64'(wet1_q);
        m2_q <= 64'(accr_q) * 64'(wet2_q);
        m3_q <= 64'(inl_q) * 64'(dry_q2);
        m4_q <= 64'(accr_q) * 64'(wet1_q);
        m5_q <= 64'(accl_q) * 64'(wet2_q);
        m6_q <= 64'(inr_q) * 64'(dry_q2);
      end
      default: ;
    endcase
  end

  // Lowpass stores, line positions and allpass lap flags.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ap_lap_q <= '0;
      for (int i = 0; i < NComb; i++) lp_q[i] <= '0;
      for (int i = 0; i < NComb; i++) cpos_q[i] <= '0;
      for (int i = 0; i < NAp; i++) apos_q[i] <= '0;
    end else begin
      if (state_q == StCombWr) begin
        lp_q[cix] <= lpn_q;
        cpos_q[cix] <= (cpos_cur == c_len(int'(cix)) - 1'b1) ? '0 : cpos_cur + 1'b1;
      end
      if (state_q == StApWr) begin
        if (apos_cur == a_len(int'(aix)) - 1'b1) begin
          apos_q[aix] <= '0;
          ap_lap_q[aix] <= 1'b1;
        end else begin
          apos_q[aix] <= apos_cur + 1'b1;
        end
      end
    end
  end

  // Control registers and output register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StClear;
      ci_q <= '0;
      ai_q <= '0;
      clr_q <= '0;
      out_vld_q <= 1'b0;
    end else begin
      state_q <= state_d;
      ci_q <= ci_d;
      ai_q <= ai_d;
      clr_q <= clr_d;
      if (state_q == StOut && !(out_vld_q && out_stall_i)) out_vld_q <= 1'b1;
      else if (out_vld_q && !out_stall_i) out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == StOut && !(out_vld_q && out_stall_i)) begin
      out_q.out_left <= sat(rnd16(m1_q + m2_q + m3_q));
      out_q.out_right <= sat(rnd16(m4_q + m5_q + m6_q));
    end
  end

  assign out_valid_o = out_vld_q;
  assign out_data_o = out_q;

  // A frame is only taken while the sequencer is idle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> state_q == StCoef)
    else $error("frame accepted outside idle");
  // No frame is taken during the clearing pass.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == StClear |-> in_stall_o)
    else $error("frame accepted during clear");
  // A waiting result is never overwritten.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_vld_q && out_stall_i) |=> out_vld_q && $stable(out_q))
    else $error("stalled result changed");

endmodule

// ----- sv/scar_ram.sv -----
// Generic single-port-write, single-port-read RAM with registered read data.
module scar_ram #(
  parameter int Width = 24,
  parameter int Depth = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule
